/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion wrappers shared by the rtl; define NO_ASSERTIONS to drop them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain property checked every clock outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/sctp_pkg.sv */
// ----------------------------------------------------------------------------
// sctp_pkg
// types and constants for the scaled chunky-to-planar converter
// ----------------------------------------------------------------------------
package sctp_pkg;

    localparam int WORD_BITS  = 32;
    localparam int PIX_BITS   = 3;
    localparam int OUT_FIELDS = 3;
    localparam int SCALE_W    = 4;
    localparam int ROW_IN_W   = 60;
    localparam int XW         = $clog2(WORD_BITS + 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    // per-cycle commands from the stepper to the plane shifters
    typedef struct packed {
        logic busy;
        logic load;
        logic emit;
        logic adv;
        logic pad;
        logic last;
    } t_step;

endpackage

/* rtl/sctp_dda.sv */
// ----------------------------------------------------------------------------
// sctp_dda
// integer dda stepper: one emit, advance or pad command per cycle
// ----------------------------------------------------------------------------
module sctp_dda #(
    parameter int SRC_WIDTH  = 20,
    parameter int NUM_SCALES = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sctp_pkg::SCALE_W-1:0]  i_scale_step,
    output sctp_pkg::t_step               o_step
);
    import sctp_pkg::*;

    `include "assert_macros.svh"

    localparam int WW = $clog2(SRC_WIDTH + 1);
    localparam int EW = $clog2(2 * SRC_WIDTH);

    t_state        r_state, n_state;
    logic [EW-1:0] r_e, n_e;
    logic [XW-1:0] r_x, n_x;
    logic [WW-1:0] r_width, n_width;

    logic [SCALE_W-1:0] sat;
    logic               shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= n_e;
        r_x     <= n_x;
        r_width <= n_width;
    end

    always_comb begin
        n_state = r_state;
        n_e     = r_e;
        n_x     = r_x;
        n_width = r_width;
        o_step  = '0;
        shift   = 1'b0;
        sat     = i_scale_step;
        if (i_scale_step >= SCALE_W'(NUM_SCALES)) begin
            sat = SCALE_W'(NUM_SCALES - 1);
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_step.load = 1'b1;
                    n_e         = '0;
                    n_x         = '0;
                    n_width     = WW'(SRC_WIDTH) - WW'(sat);
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                o_step.busy = 1'b1;
                if (r_x < XW'(r_width)) begin
                    // error term e = x*src - s*width; emit while it is below width
                    if (r_e >= EW'(r_width)) begin
                        o_step.adv = 1'b1;
                        n_e        = r_e - EW'(r_width);
                    end else begin
                        o_step.emit = 1'b1;
                        shift       = 1'b1;
                        n_e         = r_e + EW'(SRC_WIDTH);
                    end
                end else begin
                    o_step.pad = 1'b1;
                    shift      = 1'b1;
                end
                if (shift) begin
                    n_x = r_x + XW'(1);
                    if (r_x == XW'(WORD_BITS - 1)) begin
                        o_step.last = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_e_bound, i_clk, i_rst_n, r_state == S_IDLE || r_e <= EW'(2 * SRC_WIDTH - 1))
    `ASSERT_NEXT(a_load_init, i_clk, i_rst_n, o_step.load, r_x == '0 && r_e == '0)
    `ASSERT_IMPL(a_x_bound, i_clk, i_rst_n, r_state == S_RUN, r_x < XW'(WORD_BITS))

endmodule

/* rtl/sctp_planes.sv */
// ----------------------------------------------------------------------------
// sctp_planes
// pixel shift register and the three bitplane shift registers
// ----------------------------------------------------------------------------
module sctp_planes #(
    parameter int SRC_WIDTH = 20,
    parameter int PLANES    = 3
) (
    input  logic                           i_clk,
    input  sctp_pkg::t_step                i_step,
    input  logic [sctp_pkg::ROW_IN_W-1:0]  i_row_pixels,
    output logic [sctp_pkg::WORD_BITS-1:0] o_plane_zero,
    output logic [sctp_pkg::WORD_BITS-1:0] o_plane_one,
    output logic [sctp_pkg::WORD_BITS-1:0] o_plane_two
);
    import sctp_pkg::*;

    localparam int ROW_W = PIX_BITS * SRC_WIDTH;

    logic [ROW_W-1:0]     r_row, n_row;
    logic [WORD_BITS-1:0] r_plane [OUT_FIELDS];
    logic [WORD_BITS-1:0] n_plane [OUT_FIELDS];
    logic [OUT_FIELDS-1:0] pix_bit;

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        for (int p = 0; p < OUT_FIELDS; p++) begin
            r_plane[p] <= n_plane[p];
        end
    end

    always_comb begin
        // planes past PLANES stay zero
        for (int p = 0; p < OUT_FIELDS; p++) begin
            pix_bit[p] = (p < PLANES) ? r_row[p] : 1'b0;
        end
        n_row = r_row;
        for (int p = 0; p < OUT_FIELDS; p++) begin
            n_plane[p] = r_plane[p];
        end
        priority if (i_step.load) begin
            n_row = ROW_W'(i_row_pixels);
            for (int p = 0; p < OUT_FIELDS; p++) begin
                n_plane[p] = '0;
            end
        end else if (i_step.adv) begin
            n_row = r_row >> PIX_BITS;
        end else if (i_step.emit) begin
            for (int p = 0; p < OUT_FIELDS; p++) begin
                n_plane[p] = {r_plane[p][WORD_BITS-2:0], pix_bit[p]};
            end
        end else if (i_step.pad) begin
            for (int p = 0; p < OUT_FIELDS; p++) begin
                n_plane[p] = {r_plane[p][WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_plane_zero = r_plane[0];
    assign o_plane_one  = r_plane[1];
    assign o_plane_two  = r_plane[2];

endmodule

/* rtl/scaled_chunky_to_planar_top.sv */
// ----------------------------------------------------------------------------
// scaled_chunky_to_planar_top
// shrinks one chunky glyph row and splits it into three bitplane words
// ----------------------------------------------------------------------------
// usage:
//   raise start with scale_step and row_pixels while busy is low; the item is
//   taken on that edge and busy goes high the next cycle.
//   the stepper issues one command per cycle: emit a column, advance to the
//   next source pixel, or pad with zero until all 32 plane bits are shifted.
//   a run issues one shift per plane bit and one advance per source step,
//   s in all, where s = floor((w-1)*SRC_WIDTH/w) is the last source index;
//   w = SRC_WIDTH - scale_step, with scale_step capped at NUM_SCALES - 1.
//   o_valid pulses for one cycle after the run with the plane words; busy is
//   already low in that cycle, so the next start may be taken there.
//   one row in flight at a time; a new start is taken only while busy is low.
//   the result is not held: the receiver must take it on the o_valid cycle.
//   synchronous reset returns the stepper to idle and drops o_valid.
// ----------------------------------------------------------------------------
module scaled_chunky_to_planar_top #(
    parameter int SRC_WIDTH  = 20,
    parameter int NUM_SCALES = 9,
    parameter int PLANES     = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sctp_pkg::SCALE_W-1:0]   i_scale_step,
    input  logic [sctp_pkg::ROW_IN_W-1:0]  i_row_pixels,
    output logic                           o_valid,
    output logic [sctp_pkg::WORD_BITS-1:0] o_plane_zero,
    output logic [sctp_pkg::WORD_BITS-1:0] o_plane_one,
    output logic [sctp_pkg::WORD_BITS-1:0] o_plane_two
);
    import sctp_pkg::*;

    `include "assert_macros.svh"

    t_step step;
    logic  r_valid, n_valid;

    sctp_dda #(
        .SRC_WIDTH  (SRC_WIDTH),
        .NUM_SCALES (NUM_SCALES)
    ) u_dda (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_scale_step (i_scale_step),
        .o_step       (step)
    );

    sctp_planes #(
        .SRC_WIDTH (SRC_WIDTH),
        .PLANES    (PLANES)
    ) u_planes (
        .i_clk        (i_clk),
        .i_step       (step),
        .i_row_pixels (i_row_pixels),
        .o_plane_zero (o_plane_zero),
        .o_plane_one  (o_plane_one),
        .o_plane_two  (o_plane_two)
    );

    assign n_valid = step.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign busy    = step.busy;
    assign o_valid = r_valid;

    `ASSERT_IMPL(a_valid_ends_run, i_clk, i_rst_n, r_valid, $past(step.busy) && !step.busy)
    `ASSERT_NEXT(a_run_holds, i_clk, i_rst_n, step.busy && !step.last, step.busy)

endmodule
